FILE: design/ttee_pkg.sv
`default_nettype none
package ttee_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ID_W = 6;
  localparam int unsigned PORT_TIME_W = 32;
  localparam int unsigned DEST_W = 8;

  localparam int unsigned TIMER_SLOTS_DEF = 64;
  localparam int unsigned TIME_BITS_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_KILL = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic promote;
    logic arm;
    logic kill;
    logic retire;
  } flag_ctl_t;

endpackage
`default_nettype wire

FILE: design/timer_table_expiry_engine_core.sv
`default_nettype none
// Timer table with one slot per timer id. A set or kill command gives a single result, which
// appears on the cycle after the transfer. A tick scans every slot: the slot memory has one
// read port, so the scan reads and evaluates one slot per cycle, and a flush state then
// delivers the final result. Firing results follow the scan in ascending id order, each
// valid_o for exactly one cycle; the receiver cannot stall them, so it must take every strobe.
// busy_o is high while a tick is in progress and start_i is ignored then.
module timer_table_expiry_engine_core
  import ttee_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [OPCODE_W-1:0]    opcode_i,
  input  wire logic [ID_W-1:0]        timer_id_i,
  input  wire logic [PORT_TIME_W-1:0] interval_i,
  input  wire logic                   repeat_req_i,
  input  wire logic [DEST_W-1:0]      dest_i,
  input  wire logic [PORT_TIME_W-1:0] now_i,
  output logic                        busy_o,
  output logic                        valid_o,
  output logic                        fired_o,
  output logic [ID_W-1:0]             fired_id_o,
  output logic [DEST_W-1:0]           fired_dest_o,
  output logic                        accepted_o,
  output logic                        last_o
);

  localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned WORD_W = 2 * TIME_BITS + 1 + DEST_W;

  flag_ctl_t         flag_ctl;
  logic [AW-1:0]     req_idx, scan_idx;
  logic              req_busy, scan_act;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  ttee_scan_ctrl #(
    .NSLOT  (TIMER_SLOTS),
    .TB     (TIME_BITS),
    .AW     (AW),
    .WORD_W (WORD_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .opcode_i     (opcode_i),
    .timer_id_i   (timer_id_i),
    .interval_i   (interval_i),
    .repeat_req_i (repeat_req_i),
    .dest_i       (dest_i),
    .now_i        (now_i),
    .busy_o       (busy_o),
    .valid_o      (valid_o),
    .fired_o      (fired_o),
    .fired_id_o   (fired_id_o),
    .fired_dest_o (fired_dest_o),
    .accepted_o   (accepted_o),
    .last_o       (last_o),
    .flag_ctl_o   (flag_ctl),
    .req_idx_o    (req_idx),
    .scan_idx_o   (scan_idx),
    .req_busy_i   (req_busy),
    .scan_act_i   (scan_act),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  ttee_flags #(
    .NSLOT (TIMER_SLOTS),
    .AW    (AW)
  ) u_flags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (flag_ctl),
    .req_idx_i  (req_idx),
    .scan_idx_i (scan_idx),
    .req_busy_o (req_busy),
    .scan_act_o (scan_act)
  );

  ttee_slot_mem #(
    .DEPTH (TIMER_SLOTS),
    .WIDTH (WORD_W),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

FILE: design/ttee_slot_mem.sv
`default_nettype none
module ttee_slot_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 73,
  parameter int unsigned AW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/ttee_flags.sv
`default_nettype none
module ttee_flags
  import ttee_pkg::*;
#(
  parameter int unsigned NSLOT = TIMER_SLOTS_DEF,
  parameter int unsigned AW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire flag_ctl_t     ctl_i,
  input  wire logic [AW-1:0] req_idx_i,
  input  wire logic [AW-1:0] scan_idx_i,
  output logic               req_busy_o,
  output logic               scan_act_o
);

  logic [NSLOT-1:0] act_q, act_d;
  logic [NSLOT-1:0] pend_q, pend_d;

  always_comb begin
    act_d  = act_q;
    pend_d = pend_q;
    if (ctl_i.promote) begin
      act_d  = act_q | pend_q;
      pend_d = '0;
    end
    if (ctl_i.arm) begin
      pend_d[req_idx_i] = 1'b1;
    end
    if (ctl_i.kill) begin
      act_d[req_idx_i] = 1'b0;
    end
    if (ctl_i.retire) begin
      act_d[scan_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      pend_q <= '0;
    end else begin
      act_q  <= act_d;
      pend_q <= pend_d;
    end
  end

  assign req_busy_o = act_q[req_idx_i] | pend_q[req_idx_i];
  assign scan_act_o = act_q[scan_idx_i];

endmodule
`default_nettype wire

FILE: design/ttee_scan_ctrl.sv
`default_nettype none
module ttee_scan_ctrl
  import ttee_pkg::*;
#(
  parameter int unsigned NSLOT = TIMER_SLOTS_DEF,
  parameter int unsigned TB = TIME_BITS_DEF,
  parameter int unsigned AW = 6,
  parameter int unsigned WORD_W = 2 * TB + 1 + DEST_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [OPCODE_W-1:0]    opcode_i,
  input  wire logic [ID_W-1:0]        timer_id_i,
  input  wire logic [PORT_TIME_W-1:0] interval_i,
  input  wire logic                   repeat_req_i,
  input  wire logic [DEST_W-1:0]      dest_i,
  input  wire logic [PORT_TIME_W-1:0] now_i,
  output logic                        busy_o,
  output logic                        valid_o,
  output logic                        fired_o,
  output logic [ID_W-1:0]             fired_id_o,
  output logic [DEST_W-1:0]           fired_dest_o,
  output logic                        accepted_o,
  output logic                        last_o,
  output flag_ctl_t                   flag_ctl_o,
  output logic [AW-1:0]               req_idx_o,
  output logic [AW-1:0]               scan_idx_o,
  input  wire logic                   req_busy_i,
  input  wire logic                   scan_act_i,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [WORD_W-1:0]           mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  wire logic [WORD_W-1:0]      mem_rdata_i
);

  localparam logic [AW-1:0] LAST_IDX = AW'(NSLOT - 1);

  state_e state_q, state_d;
  logic [AW-1:0] eval_idx_q, eval_idx_d;
  logic [TB-1:0] now_q, now_d;

  logic              buf_vld_q, buf_vld_d;
  logic [AW-1:0]     buf_id_q, buf_id_d;
  logic [DEST_W-1:0] buf_dest_q, buf_dest_d;

  logic              valid_q, valid_d;
  logic              fired_q, fired_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [DEST_W-1:0] dest_q, dest_d;
  logic              acc_q, acc_d;
  logic              last_q, last_d;

  logic [TB-1:0]     in_ivl, in_now;
  logic [TB-1:0]     r_ivl, r_start, elapsed;
  logic              r_rep;
  logic [DEST_W-1:0] r_dest;
  logic              hit, in_range;

  assign in_ivl  = TB'(interval_i);
  assign in_now  = TB'(now_i);
  assign r_ivl   = mem_rdata_i[WORD_W-1 -: TB];
  assign r_start = mem_rdata_i[WORD_W-1-TB -: TB];
  assign r_rep   = mem_rdata_i[DEST_W];
  assign r_dest  = mem_rdata_i[DEST_W-1:0];
  assign elapsed = now_q - r_start;
  assign hit     = scan_act_i && (r_ivl != '0) && (elapsed >= r_ivl);

  assign in_range  = {26'd0, timer_id_i} < 32'(NSLOT);
  assign req_idx_o = AW'(timer_id_i);
  assign scan_idx_o = eval_idx_q;

  always_comb begin
    state_d     = state_q;
    eval_idx_d  = eval_idx_q;
    now_d       = now_q;
    buf_vld_d   = buf_vld_q;
    buf_id_d    = buf_id_q;
    buf_dest_d  = buf_dest_q;
    valid_d     = 1'b0;
    fired_d     = 1'b0;
    id_d        = '0;
    dest_d      = '0;
    acc_d       = 1'b0;
    last_d      = 1'b0;
    flag_ctl_o  = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = req_idx_o;
    mem_wdata_o = {in_ivl, in_now, repeat_req_i, dest_i};
    mem_raddr_o = eval_idx_q + AW'(1);

    case (state_q)
      ST_IDLE: begin
        mem_raddr_o = '0;
        if (start_i) begin
          case (opcode_e'(opcode_i))
            OP_TICK: begin
              flag_ctl_o.promote = 1'b1;
              eval_idx_d = '0;
              now_d      = in_now;
              buf_vld_d  = 1'b0;
              state_d    = ST_SCAN;
            end
            OP_SET: begin
              valid_d = 1'b1;
              last_d  = 1'b1;
              if (in_range && !req_busy_i) begin
                flag_ctl_o.arm = 1'b1;
                mem_we_o = 1'b1;
                acc_d    = 1'b1;
              end
            end
            OP_KILL: begin
              valid_d = 1'b1;
              last_d  = 1'b1;
              acc_d   = 1'b1;
              flag_ctl_o.kill = in_range;
            end
            default: begin
              valid_d = 1'b1;
              last_d  = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mem_waddr_o = eval_idx_q;
          mem_wdata_o = {r_ivl, now_q, r_rep, r_dest};
          mem_we_o    = r_rep;
          flag_ctl_o.retire = !r_rep;
          if (buf_vld_q) begin
            valid_d = 1'b1;
            fired_d = 1'b1;
            id_d    = ID_W'(buf_id_q);
            dest_d  = buf_dest_q;
            acc_d   = 1'b1;
          end
          buf_vld_d  = 1'b1;
          buf_id_d   = eval_idx_q;
          buf_dest_d = r_dest;
        end
        if (eval_idx_q == LAST_IDX) begin
          state_d = ST_FLUSH;
        end else begin
          eval_idx_d = eval_idx_q + AW'(1);
        end
      end
      ST_FLUSH: begin
        valid_d = 1'b1;
        acc_d   = 1'b1;
        last_d  = 1'b1;
        if (buf_vld_q) begin
          fired_d = 1'b1;
          id_d    = ID_W'(buf_id_q);
          dest_d  = buf_dest_q;
        end
        buf_vld_d = 1'b0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      buf_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      buf_vld_q <= buf_vld_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= eval_idx_d;
    now_q      <= now_d;
    buf_id_q   <= buf_id_d;
    buf_dest_q <= buf_dest_d;
    fired_q    <= fired_d;
    id_q       <= id_d;
    dest_q     <= dest_d;
    acc_q      <= acc_d;
    last_q     <= last_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign fired_o      = fired_q;
  assign fired_id_o   = id_q;
  assign fired_dest_o = dest_q;
  assign accepted_o   = acc_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire
